// ===== hdl/ptd_pkg.sv =====
// Shared types and constants for the palette texel decoder.
package ptd_pkg;

    localparam logic [2:0] FMT_A3I5   = 3'd1;
    localparam logic [2:0] FMT_2BPP   = 3'd2;
    localparam logic [2:0] FMT_4BPP   = 3'd3;
    localparam logic [2:0] FMT_8BPP   = 3'd4;
    localparam logic [2:0] FMT_A5I3   = 3'd6;
    localparam logic [2:0] FMT_DIRECT = 3'd7;

    localparam logic [2:0] FMT_RESET = FMT_8BPP;

    localparam logic CFG_TEXTURE_FORMAT     = 1'b0;
    localparam logic CFG_COLOR0_TRANSPARENT = 1'b1;

    localparam logic MODE_PALETTE_WRITE = 1'b0;
    localparam logic MODE_TEXEL         = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  palette_index;
        logic [14:0] palette_color;
        logic [15:0] texel_data;
    } ptd_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_pixel;
        logic       format_error;
    } ptd_out_t;

endpackage

// ===== hdl/palette_texel_decoder_core.sv =====
// Top level of the palette texel decoder: input register, palette and pixel register.
//
// Each accepted word either writes one palette entry or decodes its texel data
// into pixels, one pixel per cycle while pixel_stall is low: a 2bpp word gives four
// pixels, a 4bpp word two, and every other format one. The rate is set by
// the single read port of the palette, which serves one pixel per cycle. Each
// word sits in the input register while the palette is read into the pixel
// register, one pixel at a time. The palette reads as zero after reset
// through one valid bit per entry, so no clearing pass is needed and words
// are taken at once.
module palette_texel_decoder_core
    import ptd_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     texel_valid,
    output logic     texel_stall,
    input  ptd_in_t  texel_word,
    output logic     pixel_valid,
    input  logic     pixel_stall,
    output ptd_out_t pixel_word,
    input  logic     cfg_write,
    input  logic     cfg_index,
    input  logic [2:0] cfg_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] DEPTH_LIMIT = 9'(PALETTE_DEPTH);

    logic [2:0] format_reg;
    logic       transparent_reg;

    logic       a_valid_reg;
    logic       a_valid_next;
    ptd_in_t    a_item_reg;
    logic [1:0] a_cnt_reg;
    logic [1:0] a_cnt_next;

    logic       o_valid_reg;
    logic       o_valid_next;
    logic       o_use_pal_reg;
    logic [14:0] o_direct_reg;
    logic [7:0] o_alpha_reg;
    logic       o_last_reg;
    logic       o_err_reg;
    logic [14:0] rd_data_reg;
    logic       rd_hit_reg;

    logic [14:0] pal_mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] pal_valid_reg;

    logic       out_free;
    logic       emit;
    logic       is_last;
    logic       a_done;
    logic       accept;
    logic [1:0] last_cnt;
    logic [7:0] tex_byte;
    logic [7:0] pix_idx;
    logic       pix_use_pal;
    logic [14:0] pix_direct;
    logic [7:0] pix_alpha;
    logic       pix_err;
    logic [7:0] idx_alpha;
    logic       rd_in_range;
    logic       wr_in_range;
    logic       pal_we;
    logic [14:0] color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg      <= FMT_RESET;
            transparent_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TEXTURE_FORMAT:     format_reg      <= cfg_data;
                CFG_COLOR0_TRANSPARENT: transparent_reg <= cfg_data[0];
                default:                format_reg      <= format_reg;
            endcase
        end
    end

    assign out_free = !o_valid_reg || !pixel_stall;
    assign tex_byte = a_item_reg.texel_data[7:0];

    always_comb
    begin
        unique case (format_reg)
            FMT_2BPP: last_cnt = 2'd3;
            FMT_4BPP: last_cnt = 2'd1;
            default:  last_cnt = 2'd0;
        endcase
    end

    assign is_last = (a_cnt_reg == last_cnt);
    assign emit    = a_valid_reg && (a_item_reg.mode == MODE_TEXEL) && out_free;
    assign a_done  = a_valid_reg && ((a_item_reg.mode == MODE_PALETTE_WRITE) ||
                                     (out_free && is_last));
    assign texel_stall = a_valid_reg && !a_done;
    assign accept      = texel_valid && !texel_stall;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_cnt_next   = a_cnt_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
            a_cnt_next   = 2'd0;
        end
        else if (a_done)
        begin
            a_valid_next = 1'b0;
        end
        else if (emit)
        begin
            a_cnt_next = a_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_cnt_reg   <= 2'd0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            a_cnt_reg   <= a_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg <= texel_word;
        end
    end

    always_comb
    begin
        pix_idx     = tex_byte;
        pix_use_pal = 1'b1;
        pix_direct  = 15'd0;
        pix_err     = 1'b0;
        idx_alpha   = 8'hFF;
        pix_alpha   = 8'hFF;
        unique case (format_reg)
            FMT_A3I5:
            begin
                pix_idx   = {3'd0, tex_byte[4:0]};
                pix_alpha = {tex_byte[7:5], tex_byte[7:6], 3'd0};
            end
            FMT_2BPP:
            begin
                pix_idx = {6'd0, tex_byte[{a_cnt_reg, 1'b0} +: 2]};
            end
            FMT_4BPP:
            begin
                pix_idx = a_cnt_reg[0] ? {4'd0, tex_byte[7:4]} : {4'd0, tex_byte[3:0]};
            end
            FMT_8BPP:
            begin
                pix_idx = tex_byte;
            end
            FMT_A5I3:
            begin
                pix_idx   = {5'd0, tex_byte[2:0]};
                pix_alpha = {tex_byte[7:3], 3'd0};
            end
            FMT_DIRECT:
            begin
                pix_use_pal = 1'b0;
                pix_direct  = a_item_reg.texel_data[14:0];
                pix_alpha   = a_item_reg.texel_data[15] ? 8'hFF : 8'h00;
            end
            default:
            begin
                pix_use_pal = 1'b0;
                pix_alpha   = 8'h00;
                pix_err     = 1'b1;
            end
        endcase
        if (transparent_reg && (pix_idx == 8'd0))
        begin
            idx_alpha = 8'h00;
        end
        if ((format_reg == FMT_2BPP) || (format_reg == FMT_4BPP) ||
            (format_reg == FMT_8BPP))
        begin
            pix_alpha = idx_alpha;
        end
    end

    assign rd_in_range = ({1'b0, pix_idx} < DEPTH_LIMIT);
    assign wr_in_range = ({1'b0, a_item_reg.palette_index} < DEPTH_LIMIT);
    assign pal_we = a_valid_reg && (a_item_reg.mode == MODE_PALETTE_WRITE) && wr_in_range;

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[a_item_reg.palette_index[AW-1:0]] <= a_item_reg.palette_color;
        end
        if (emit)
        begin
            rd_data_reg <= pal_mem[pix_idx[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= '0;
        end
        else if (pal_we)
        begin
            pal_valid_reg[a_item_reg.palette_index[AW-1:0]] <= 1'b1;
        end
    end

    assign o_valid_next = out_free ? emit : o_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rd_hit_reg    <= rd_in_range && pal_valid_reg[pix_idx[AW-1:0]];
            o_use_pal_reg <= pix_use_pal;
            o_direct_reg  <= pix_direct;
            o_alpha_reg   <= pix_alpha;
            o_last_reg    <= is_last;
            o_err_reg     <= pix_err;
        end
    end

    always_comb
    begin
        if (o_use_pal_reg)
        begin
            color = rd_hit_reg ? rd_data_reg : 15'd0;
        end
        else
        begin
            color = o_direct_reg;
        end
    end

    assign pixel_valid             = o_valid_reg;
    assign pixel_word.red          = {color[4:0], 3'd0};
    assign pixel_word.green        = {color[9:5], 3'd0};
    assign pixel_word.blue         = {color[14:10], 3'd0};
    assign pixel_word.alpha        = o_alpha_reg;
    assign pixel_word.last_pixel   = o_last_reg;
    assign pixel_word.format_error = o_err_reg;

`ifndef ASSERT_OFF
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_word.format_error |-> pixel_word.last_pixel)
        else $error("Format error word is not marked as the last pixel.");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (a_cnt_reg <= last_cnt))
        else $error("Pixel counter ran past the last pixel of the word.");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !a_valid_reg |-> !texel_stall)
        else $error("Input stalled while the input register is empty.");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && (a_item_reg.mode == MODE_TEXEL) && !out_free
        |=> a_valid_reg && $stable(a_cnt_reg))
        else $error("Texel word moved on while the pixel register was blocked.");
`endif

endmodule

// ===== tb/sv/tb_palette_texel_decoder_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for palette_texel_decoder_core against a pixel predictor.
module tb_palette_texel_decoder_core;
    import ptd_pkg::*;

    localparam int PAL_DEPTH = 256;
    localparam int RANDOM_PER_PHASE = 11;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [2:0] FMT_NONE_0 = 3'd0;
    localparam logic [2:0] FMT_NONE_5 = 3'd5;

    class pixel_scoreboard;
        logic [14:0] palette_mem [PAL_DEPTH];
        logic [2:0]  format_reg;
        logic        zero_clear;
        ptd_out_t    expected_q [$];

        function new();
            foreach (palette_mem[i])
            begin
                palette_mem[i] = '0;
            end
            format_reg = FMT_RESET;
            zero_clear = 1'b0;
        endfunction

        function void write_reg(logic idx, logic [2:0] val);
            if (idx == CFG_TEXTURE_FORMAT)
            begin
                format_reg = val;
            end
            else
            begin
                zero_clear = val[0];
            end
        endfunction

        function logic [7:0] index_alpha(logic [7:0] idx);
            return (zero_clear && idx == 8'd0) ? 8'h00 : 8'hFF;
        endfunction

        function void push_pixel(logic [14:0] color, logic [7:0] alpha, logic last);
            ptd_out_t p;
            p.red          = {color[4:0], 3'b000};
            p.green        = {color[9:5], 3'b000};
            p.blue         = {color[14:10], 3'b000};
            p.alpha        = alpha;
            p.last_pixel   = last;
            p.format_error = 1'b0;
            expected_q = {expected_q, p};
        endfunction

        // Works out the pixels that one accepted word causes.
        function void note_word(ptd_in_t w);
            logic [7:0] b;
            logic [1:0] pair;
            logic [3:0] nib;
            logic [2:0] a3;
            logic [4:0] a5;
            ptd_out_t   p;
            b = w.texel_data[7:0];
            if (w.mode == MODE_PALETTE_WRITE)
            begin
                palette_mem[w.palette_index] = w.palette_color;
                return;
            end
            case (format_reg)
                FMT_A3I5:
                begin
                    a3 = b[7:5];
                    a5 = {a3, 2'b00} + {3'b000, a3[2:1]};
                    push_pixel(palette_mem[b[4:0]], {a5, 3'b000}, 1'b1);
                end
                FMT_2BPP:
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        pair = b[2*k +: 2];
                        push_pixel(palette_mem[pair], index_alpha({6'd0, pair}), k == 3);
                    end
                end
                FMT_4BPP:
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        nib = b[4*k +: 4];
                        push_pixel(palette_mem[nib], index_alpha({4'd0, nib}), k == 1);
                    end
                end
                FMT_8BPP:
                begin
                    push_pixel(palette_mem[b], index_alpha(b), 1'b1);
                end
                FMT_A5I3:
                begin
                    push_pixel(palette_mem[b[2:0]], {b[7:3], 3'b000}, 1'b1);
                end
                FMT_DIRECT:
                begin
                    push_pixel(w.texel_data[14:0], {8{w.texel_data[15]}}, 1'b1);
                end
                default:
                begin
                    p = '0;
                    p.last_pixel   = 1'b1;
                    p.format_error = 1'b1;
                    expected_q = {expected_q, p};
                end
            endcase
        endfunction

        function string check_pixel(ptd_out_t got);
            ptd_out_t want;
            string    msg;
            if (expected_q.size() == 0)
            begin
                return $sformatf("pixel %h arrived with nothing expected", got);
            end
            want = expected_q.pop_front();
            msg = "";
            if (got.red !== want.red)
                msg = {msg, $sformatf(" red %h/%h", got.red, want.red)};
            if (got.green !== want.green)
                msg = {msg, $sformatf(" green %h/%h", got.green, want.green)};
            if (got.blue !== want.blue)
                msg = {msg, $sformatf(" blue %h/%h", got.blue, want.blue)};
            if (got.alpha !== want.alpha)
                msg = {msg, $sformatf(" alpha %h/%h", got.alpha, want.alpha)};
            if (got.last_pixel !== want.last_pixel)
                msg = {msg, $sformatf(" last_pixel %b/%b", got.last_pixel, want.last_pixel)};
            if (got.format_error !== want.format_error)
                msg = {msg, $sformatf(" format_error %b/%b", got.format_error,
                                      want.format_error)};
            if (msg != "")
                msg = {"pixel mismatch (got/expected):", msg};
            return msg;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       texel_valid;
    logic       texel_stall;
    ptd_in_t    texel_word;
    logic       pixel_valid;
    logic       pixel_stall = 1'b0;
    ptd_out_t   pixel_word;
    logic       cfg_write;
    logic       cfg_index;
    logic [2:0] cfg_data;

    pixel_scoreboard sb;
    int          mismatch_count = 0;
    int          burst_left = 4;
    logic [15:0] stall_cycle = '0;

    palette_texel_decoder_core #(
        .PALETTE_DEPTH(PAL_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .texel_valid (texel_valid),
        .texel_stall (texel_stall),
        .texel_word  (texel_word),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_word  (pixel_word),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        string msg;
        if (rst_n === 1'b1 && pixel_valid && !pixel_stall)
        begin
            msg = sb.check_pixel(pixel_word);
            if (msg != "")
                report_mismatch(msg);
        end
        stall_cycle <= stall_cycle + 16'd1;
        case (stall_cycle[7:6])
            2'd0: pixel_stall <= 1'b0;
            2'd1: pixel_stall <= ($urandom_range(0, 2) == 0);
            2'd2: pixel_stall <= ($urandom_range(0, 3) != 0);
            default: pixel_stall <= stall_cycle[0];
        endcase
    end

    // Holds valid across a burst; drops it only when a gap follows.
    task automatic send_word(ptd_in_t w);
        int gap;
        texel_valid <= 1'b1;
        texel_word  <= w;
        @(posedge clk);
        while (texel_stall)
            @(posedge clk);
        sb.note_word(w);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                texel_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_palette(logic [7:0] idx, logic [14:0] color);
        ptd_in_t w;
        w = '0;
        w.mode          = MODE_PALETTE_WRITE;
        w.palette_index = idx;
        w.palette_color = color;
        w.texel_data    = 16'($urandom);
        send_word(w);
    endtask

    task automatic send_texel(logic [15:0] data);
        ptd_in_t w;
        w = '0;
        w.mode          = MODE_TEXEL;
        w.palette_index = 8'($urandom);
        w.palette_color = 15'($urandom);
        w.texel_data    = data;
        send_word(w);
    endtask

    function automatic ptd_in_t random_word();
        ptd_in_t w;
        w.mode          = ($urandom_range(0, 3) != 0) ? MODE_TEXEL : MODE_PALETTE_WRITE;
        w.palette_index = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        w.palette_color = 15'($urandom);
        w.texel_data    = 16'($urandom);
        return w;
    endfunction

    task automatic drain();
        texel_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [2:0] fmt, logic zero_clear);
        cfg_write <= 1'b1;
        cfg_index <= CFG_TEXTURE_FORMAT;
        cfg_data  <= fmt;
        @(posedge clk);
        sb.write_reg(CFG_TEXTURE_FORMAT, fmt);
        cfg_index <= CFG_COLOR0_TRANSPARENT;
        cfg_data  <= {2'b00, zero_clear};
        @(posedge clk);
        sb.write_reg(CFG_COLOR0_TRANSPARENT, {2'b00, zero_clear});
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(logic [2:0] fmt, logic zero_clear, logic [15:0] first_data);
        configure(fmt, zero_clear);
        send_texel(first_data);
        repeat (RANDOM_PER_PHASE) send_word(random_word());
        drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        texel_valid = 1'b0;
        texel_word  = '0;
        cfg_write   = 1'b0;
        cfg_index   = CFG_TEXTURE_FORMAT;
        cfg_data    = '0;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: reads of the cleared palette, then extreme colors.
        send_texel(16'h0000);
        send_texel(16'h00FF);
        write_palette(8'd0, 15'h7FFF);
        write_palette(8'd1, 15'h001F);
        write_palette(8'd2, 15'h03E0);
        write_palette(8'd3, 15'h7C00);
        write_palette(8'd255, 15'h5555);
        write_palette(8'd31, 15'h2AAA);
        write_palette(8'd7, 15'h1234);
        write_palette(8'd15, 15'h4321);
        send_texel(16'hFF1F);
        repeat (RANDOM_PER_PHASE) send_word(random_word());
        drain();

        run_phase(FMT_8BPP, 1'b1, 16'h0000);
        run_phase(FMT_2BPP, 1'b0, 16'h00E4);
        run_phase(FMT_2BPP, 1'b1, 16'h001B);
        run_phase(FMT_4BPP, 1'b1, 16'h00F0);
        run_phase(FMT_A3I5, 1'b1, 16'h00FF);
        run_phase(FMT_A5I3, 1'b0, 16'h00F8);
        run_phase(FMT_DIRECT, 1'b0, 16'hFFFF);
        run_phase(FMT_DIRECT, 1'b1, 16'h7FFF);
        run_phase(FMT_NONE_0, 1'b0, 16'hFFFF);
        run_phase(FMT_NONE_5, 1'b1, 16'h0000);
        run_phase(FMT_4BPP, 1'b0, 16'h000F);
        run_phase(FMT_8BPP, 1'b0, 16'h00FF);

        if (mismatch_count == 0)
        begin
            $display("[palette_texel_decoder_core] OK");
        end
        else
        begin
            $display("[palette_texel_decoder_core] ERROR");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[palette_texel_decoder_core] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ptd_pkg.sv
hdl/palette_texel_decoder_core.sv
tb/sv/tb_palette_texel_decoder_core.sv
